### hdl/greedy_route_split_cost_top_defines.svh
// Assertion macros for the greedy route split cost block.
// Used by greedy_route_split_cost_top; expects clk and arst_n in scope.
`ifndef GREEDY_ROUTE_SPLIT_COST_TOP_DEFINES_SVH
`define GREEDY_ROUTE_SPLIT_COST_TOP_DEFINES_SVH
`ifndef SYNTH
// Checked while out of reset.
`define GRSC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("grsc assertion failed");
// Checked at every edge, reset included.
`define GRSC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("grsc assertion failed");
`else
`define GRSC_ASSERT(lbl, prop)
`define GRSC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### hdl/grsc_pkg.sv
// Shared types and constants for the greedy route split cost block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package grsc_pkg;

	localparam int NODE_BITS      = 5;
	localparam int NODES          = 1 << NODE_BITS;
	localparam int VALUE_BITS     = 16;
	localparam int LOAD_BITS      = VALUE_BITS + 1;
	localparam int COST_BITS      = 32;
	localparam int DIST_ADDR_BITS = 2 * NODE_BITS;
	localparam int DIST_DEPTH     = 1 << DIST_ADDR_BITS;
	localparam int CMDQ_PTR_BITS  = 2;
	localparam int CMDQ_DEPTH     = 1 << CMDQ_PTR_BITS;
	localparam int OUTQ_PTR_BITS  = 2;
	localparam int OUTQ_DEPTH     = 1 << OUTQ_PTR_BITS;

	localparam logic [VALUE_BITS-1:0] CAP_RESET = VALUE_BITS'(20);
	localparam logic [NODE_BITS-1:0]  DEPOT     = '0;
	localparam logic [COST_BITS-1:0]  COST_MAX  = '1;

	typedef enum logic [1:0] {
		FUNC_WR_DEMAND = 2'd0,
		FUNC_WR_DIST   = 2'd1,
		FUNC_VISIT     = 2'd2,
		FUNC_END       = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		CMD_DIST_WRITE = 2'd0,
		CMD_VISIT      = 2'd1,
		CMD_FINISH     = 2'd2
	} cmd_kind_t;

	// Work handed from the front to the back through the command queue.
	typedef struct packed {
		cmd_kind_t                 kind;
		logic [DIST_ADDR_BITS-1:0] addr0;
		logic [DIST_ADDR_BITS-1:0] addr1;
		logic                      use_second;
		logic [VALUE_BITS-1:0]     wr_value;
		logic [NODE_BITS-1:0]      stop;
		logic                      new_route;
		logic [LOAD_BITS-1:0]      load;
		logic                      over_capacity;
	} cmd_t;

	typedef struct packed {
		logic [NODE_BITS-1:0] stop;
		logic                 new_route;
		logic [LOAD_BITS-1:0] load;
		logic [COST_BITS-1:0] cost;
		logic                 over_capacity;
		logic                 sequence_done;
	} result_t;

endpackage

`default_nettype wire

### hdl/grsc_front.sv
// Front end: accepts items, holds the demand table and capacity register,
// and decides route splits. Depends on grsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module grsc_front import grsc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [1:0]            func,
	input  wire logic [NODE_BITS-1:0]  node_a,
	input  wire logic [NODE_BITS-1:0]  node_b,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic                  cfg_valid,
	input  wire logic [VALUE_BITS-1:0] cfg_data,
	output logic                       cmd_push,
	output cmd_t                       cmd_data,
	input  wire logic                  cmd_full
);

	logic [VALUE_BITS-1:0] demand_mem [NODES];
	logic [VALUE_BITS-1:0] dem_rd_s1;
	logic                  valid_s1;
	func_t                 func_s1;
	logic [NODE_BITS-1:0]  node_a_s1;
	logic [NODE_BITS-1:0]  node_b_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic [VALUE_BITS-1:0] cap_q;
	logic [LOAD_BITS-1:0]  load_q;
	logic [NODE_BITS-1:0]  prev_q;

	func_t                 func_in;
	logic                  accept;
	logic                  needs_push;
	logic                  s1_fire;
	logic [LOAD_BITS-1:0]  dem_ext;
	logic [LOAD_BITS-1:0]  load_sum;
	logic                  close_route;
	logic                  over_cap;

	assign func_in    = func_t'(func);
	assign needs_push = (func_s1 != FUNC_WR_DEMAND);
	assign s1_fire    = valid_s1 && (!needs_push || !cmd_full);
	assign full       = valid_s1 && !s1_fire;
	assign accept     = push && !full;
	assign cmd_push   = valid_s1 && needs_push && !cmd_full;

	// A demand write lands at its own accept edge, so a later visit reads it.
	always_ff @(posedge clk) begin
		if (accept && func_in == FUNC_WR_DEMAND) begin
			demand_mem[node_a] <= value;
		end
		if (accept) begin
			dem_rd_s1 <= demand_mem[node_a];
			func_s1   <= func_in;
			node_a_s1 <= node_a;
			node_b_s1 <= node_b;
			value_s1  <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	assign dem_ext     = {1'b0, dem_rd_s1};
	assign load_sum    = load_q + dem_ext;
	assign close_route = load_sum > {1'b0, cap_q};
	assign over_cap    = dem_rd_s1 > cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= '0;
			prev_q <= DEPOT;
		end else if (s1_fire) begin
			if (func_s1 == FUNC_VISIT) begin
				load_q <= close_route ? dem_ext : load_sum;
				prev_q <= node_a_s1;
			end else if (func_s1 == FUNC_END) begin
				load_q <= '0;
				prev_q <= DEPOT;
			end
		end
	end

	always_comb begin
		cmd_data = '0;
		unique case (func_s1)
			FUNC_WR_DIST: begin
				cmd_data.kind     = CMD_DIST_WRITE;
				cmd_data.addr0    = {node_a_s1, node_b_s1};
				cmd_data.wr_value = value_s1;
			end
			FUNC_VISIT: begin
				// A closed route pays the leg home and the leg out of the depot.
				cmd_data.kind          = CMD_VISIT;
				cmd_data.addr0         = close_route ? {prev_q, DEPOT} : {prev_q, node_a_s1};
				cmd_data.addr1         = {DEPOT, node_a_s1};
				cmd_data.use_second    = close_route;
				cmd_data.stop          = node_a_s1;
				cmd_data.new_route     = close_route;
				cmd_data.load          = close_route ? dem_ext : load_sum;
				cmd_data.over_capacity = over_cap;
			end
			FUNC_END: begin
				cmd_data.kind  = CMD_FINISH;
				cmd_data.addr0 = {prev_q, DEPOT};
				cmd_data.stop  = DEPOT;
				cmd_data.load  = load_q;
			end
			FUNC_WR_DEMAND: begin
				cmd_data.kind = CMD_DIST_WRITE;
			end
		endcase
	end

endmodule

`default_nettype wire

### hdl/grsc_cmd_queue.sv
// Short command queue between the front and back halves of the block.
// Depends on grsc_pkg for cmd_t and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module grsc_cmd_queue import grsc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  cmd_t      wr_data,
	output logic      full,
	input  wire logic rd_en,
	output cmd_t      rd_data,
	output logic      empty
);

	cmd_t                   entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_BITS-1:0] wr_ptr_q;
	logic [CMDQ_PTR_BITS-1:0] rd_ptr_q;
	logic [CMDQ_PTR_BITS:0]   count_q;
	logic                     do_wr;
	logic                     do_rd;

	assign full    = (count_q == (CMDQ_PTR_BITS + 1)'(CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/grsc_back.sv
// Back end: distance table with two read ports, saturating cost accumulator
// and the result queue. Depends on grsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module grsc_back import grsc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_empty,
	input  cmd_t      cmd_data,
	output logic      cmd_pop,
	output logic      empty,
	input  wire logic pop,
	output result_t   result
);

	logic [VALUE_BITS-1:0]    dist_mem [DIST_DEPTH];
	logic [VALUE_BITS-1:0]    rd0_s1;
	logic [VALUE_BITS-1:0]    rd1_s1;
	cmd_t                     cmd_s1;
	logic                     valid_s1;
	logic [COST_BITS-1:0]     cost_q;

	result_t                  outq_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_BITS-1:0] out_wr_ptr_q;
	logic [OUTQ_PTR_BITS-1:0] out_rd_ptr_q;
	logic [OUTQ_PTR_BITS:0]   out_count_q;

	logic                     credit;
	logic [VALUE_BITS:0]      leg_sum;
	logic [COST_BITS:0]       cost_sum;
	logic [COST_BITS-1:0]     cost_next;
	result_t                  new_result;
	logic                     out_pop;

	// Room is reserved in the result queue for the item still in flight.
	assign credit  = ((out_count_q + (OUTQ_PTR_BITS + 1)'(valid_s1))
		< (OUTQ_PTR_BITS + 1)'(OUTQ_DEPTH));
	assign cmd_pop = !cmd_empty && credit;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			if (cmd_data.kind == CMD_DIST_WRITE) begin
				dist_mem[cmd_data.addr0] <= cmd_data.wr_value;
			end
			rd0_s1 <= dist_mem[cmd_data.addr0];
			rd1_s1 <= dist_mem[cmd_data.addr1];
			cmd_s1 <= cmd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_pop && (cmd_data.kind != CMD_DIST_WRITE);
		end
	end

	// Both legs are non-negative, so one saturating add of their sum matches
	// two saturating adds in a row.
	assign leg_sum   = {1'b0, rd0_s1} + (cmd_s1.use_second ? {1'b0, rd1_s1} : '0);
	assign cost_sum  = {1'b0, cost_q} + (COST_BITS + 1)'(leg_sum);
	assign cost_next = cost_sum[COST_BITS] ? COST_MAX : cost_sum[COST_BITS-1:0];

	always_comb begin
		new_result.stop          = cmd_s1.stop;
		new_result.new_route     = cmd_s1.new_route;
		new_result.load          = cmd_s1.load;
		new_result.cost          = cost_next;
		new_result.over_capacity = cmd_s1.over_capacity;
		new_result.sequence_done = (cmd_s1.kind == CMD_FINISH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_q <= '0;
		end else if (valid_s1) begin
			cost_q <= (cmd_s1.kind == CMD_FINISH) ? '0 : cost_next;
		end
	end

	assign empty   = (out_count_q == '0);
	assign out_pop = pop && !empty;
	assign result  = outq_q[out_rd_ptr_q];

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			outq_q[out_wr_ptr_q] <= new_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_ptr_q <= '0;
			out_rd_ptr_q <= '0;
			out_count_q  <= '0;
		end else begin
			if (valid_s1) begin
				out_wr_ptr_q <= out_wr_ptr_q + 1'b1;
			end
			if (out_pop) begin
				out_rd_ptr_q <= out_rd_ptr_q + 1'b1;
			end
			if (valid_s1 && !out_pop) begin
				out_count_q <= out_count_q + 1'b1;
			end else if (out_pop && !valid_s1) begin
				out_count_q <= out_count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/greedy_route_split_cost_top.sv
// Greedy vehicle route split with running distance cost.
// Usage:
//   Input items are pushed with push while full is low. Demand writes and
//   distance writes load the tables; a visit places one customer and an end
//   item closes the sequence. Each visit or end item yields one result.
//   Results wait in a four-entry queue: while empty is low the oldest one is
//   on stop, new_route, route_load, route_cost, over_capacity and
//   sequence_done, and pop takes it.
//   The capacity register is written through cfg_valid/cfg_data; cfg_ready
//   is always high. Write it only while no item is in flight.
// Timing:
//   An item goes through the front stage, command queue, back stage and result
//   queue. One item is accepted per cycle while full is low; the distance
//   table has two read ports, so a route close reads both of its legs at once.
// Reset and stalls:
//   Reset empties both queues and clears load, previous stop and cost; the
//   capacity returns to 20. Table contents are kept and must be written before
//   they are read. When pop stays low the result queue fills, the back end
//   stops draining the command queue, and full rises a few items later.
`timescale 1ns / 1ps
`default_nettype none
`include "greedy_route_split_cost_top_defines.svh"

module greedy_route_split_cost_top import grsc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [1:0]            func,
	input  wire logic [NODE_BITS-1:0]  node_a,
	input  wire logic [NODE_BITS-1:0]  node_b,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [VALUE_BITS-1:0] cfg_data,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [NODE_BITS-1:0]       stop,
	output logic                       new_route,
	output logic [LOAD_BITS-1:0]       route_load,
	output logic [COST_BITS-1:0]       route_cost,
	output logic                       over_capacity,
	output logic                       sequence_done
);

	logic    cmd_push;
	cmd_t    cmd_wr_data;
	logic    cmd_full;
	logic    cmd_pop;
	cmd_t    cmd_rd_data;
	logic    cmd_empty;
	result_t result;

	assign cfg_ready = 1'b1;

	grsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.node_a    (node_a),
		.node_b    (node_b),
		.value     (value),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.cmd_push  (cmd_push),
		.cmd_data  (cmd_wr_data),
		.cmd_full  (cmd_full)
	);

	grsc_cmd_queue u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_wr_data),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_rd_data),
		.empty   (cmd_empty)
	);

	grsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_data  (cmd_rd_data),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	assign stop          = result.stop;
	assign new_route     = result.new_route;
	assign route_load    = result.load;
	assign route_cost    = result.cost;
	assign over_capacity = result.over_capacity;
	assign sequence_done = result.sequence_done;

	// The front only pushes a command when the queue has room.
	`GRSC_ASSERT(a_cmd_no_overflow, cmd_push |-> !cmd_full)
	// An end result reports the depot and carries no visit flags.
	`GRSC_ASSERT(a_end_fields, (!empty && sequence_done) |-> (stop == DEPOT && !new_route && !over_capacity))
	// No result is offered while reset is applied.
	`GRSC_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> empty)

endmodule

`default_nettype wire
